[src/min_max_tournament_tree_defines.svh]
// Assertion macros for the min/max tournament tree.
`ifndef MIN_MAX_TOURNAMENT_TREE_DEFINES_SVH
`define MIN_MAX_TOURNAMENT_TREE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MMTT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmtt assertion failed");

// Next-cycle implication
`define MMTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmtt assertion failed");

`else

`define MMTT_ASSERT_IMP(label, clk, rst, ante, cons)
`define MMTT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/mmtt_pkg.sv]
// Shared constants, node type and combine functions for the tournament tree.
package mmtt_pkg;

  localparam int SLOT_BITS      = 10;
  localparam int KEY_BITS       = 16;
  localparam int NODE_ADDR_BITS = SLOT_BITS + 1;
  localparam int NODES          = 1 << NODE_ADDR_BITS;

  localparam logic [NODE_ADDR_BITS-1:0] ROOT_ADDR = NODE_ADDR_BITS'(1);
  localparam logic [NODE_ADDR_BITS-1:0] LAST_ADDR = NODE_ADDR_BITS'(NODES - 1);

  // Operation codes carried in tuser
  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [SLOT_BITS-1:0] slot;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  // Larger key wins, larger slot on equal keys; empty never beats occupied
  function automatic node_t pick_max(node_t a, node_t b);
    node_t r;
    if (!a.valid) begin
      r = b;
    end else if (!b.valid) begin
      r = a;
    end else if (a.key != b.key) begin
      r = (a.key > b.key) ? a : b;
    end else begin
      r = (a.slot > b.slot) ? a : b;
    end
    return r;
  endfunction

  // Smaller key wins, smaller slot on equal keys; empty never beats occupied
  function automatic node_t pick_min(node_t a, node_t b);
    node_t r;
    if (!a.valid) begin
      r = b;
    end else if (!b.valid) begin
      r = a;
    end else if (a.key != b.key) begin
      r = (a.key < b.key) ? a : b;
    end else begin
      r = (a.slot < b.slot) ? a : b;
    end
    return r;
  endfunction

endpackage

[src/min_max_tournament_tree.sv]
// Min/max tournament tree over 1024 slots with point set/clear updates.
// After reset the block clears all entries of its two node memories
// (s_tready low) before the first transfer is taken. In each update the
// accepting edge writes the leaf, the walk then goes up the levels to the root
// with one read-combine-write of the max and min node memories per level (each
// memory has a single read and a single write port), and the result register is
// loaded last. s_tready returns with the result, so a new transfer is taken only
// after the previous update is through. A waiting result does not
// block the next accept; the walk only holds at its end until the result
// register is free. Ties: the max root reports the larger slot, the min root
// the smaller slot; an empty tree reports all zeros with any_present low.
`include "min_max_tournament_tree_defines.svh"

module min_max_tournament_tree (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // slot[9:0], key[25:10], zero pad
  input  logic [0:0]  s_tuser,   // func[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // max_key[15:0], max_slot[25:16], min_key[41:26],
                                 // min_slot[51:42], zero pad
  output logic [0:0]  m_tuser    // any_present[0]
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] clr_addr;
  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] node_addr;
  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] parent_addr;
  mmtt_pkg::node_t                     cur_max;
  mmtt_pkg::node_t                     cur_min;

  // Node memories and their ports
  mmtt_pkg::node_t max_mem [mmtt_pkg::NODES];
  mmtt_pkg::node_t min_mem [mmtt_pkg::NODES];
  mmtt_pkg::node_t rd_max;
  mmtt_pkg::node_t rd_min;
  logic                                wr_en;
  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] wr_addr;
  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] rd_addr;
  mmtt_pkg::node_t                     wr_max;
  mmtt_pkg::node_t                     wr_min;

  // Input fields
  logic                           in_func;
  logic [mmtt_pkg::SLOT_BITS-1:0] in_slot;
  logic [mmtt_pkg::KEY_BITS-1:0]  in_key;
  logic [mmtt_pkg::NODE_ADDR_BITS-1:0] leaf_addr;
  mmtt_pkg::node_t                in_leaf;
  logic                           in_xfer;

  // Combined parent values
  mmtt_pkg::node_t new_max;
  mmtt_pkg::node_t new_min;

  // Result register
  logic            out_any;
  mmtt_pkg::node_t out_max;
  mmtt_pkg::node_t out_min;

  assign in_func   = s_tuser[0];
  assign in_slot   = s_tdata[9:0];
  assign in_key    = s_tdata[25:10];
  assign leaf_addr = {1'b1, in_slot};
  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid & s_tready;

  // Leaf value: clearing leaves an all-zero empty node
  always_comb begin
    in_leaf = '0;
    if (in_func == mmtt_pkg::FUNC_SET) begin
      in_leaf.valid = 1'b1;
      in_leaf.key   = in_key;
      in_leaf.slot  = in_slot;
    end
  end

  // Recombine the current node with its sibling; even address is the left child
  assign parent_addr = {1'b0, node_addr[mmtt_pkg::NODE_ADDR_BITS-1:1]};
  always_comb begin
    if (!node_addr[0]) begin
      new_max = mmtt_pkg::pick_max(cur_max, rd_max);
      new_min = mmtt_pkg::pick_min(cur_min, rd_min);
    end else begin
      new_max = mmtt_pkg::pick_max(rd_max, cur_max);
      new_min = mmtt_pkg::pick_min(rd_min, cur_min);
    end
  end

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_max  = '0;
    wr_min  = '0;
    rd_addr = leaf_addr ^ mmtt_pkg::ROOT_ADDR;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_IDLE: begin
        wr_en   = in_xfer;
        wr_addr = leaf_addr;
        wr_max  = in_leaf;
        wr_min  = in_leaf;
        rd_addr = leaf_addr ^ mmtt_pkg::ROOT_ADDR;
      end
      S_WALK: begin
        wr_en   = 1'b1;
        wr_addr = parent_addr;
        wr_max  = new_max;
        wr_min  = new_min;
        rd_addr = parent_addr ^ mmtt_pkg::ROOT_ADDR;
      end
      S_DONE: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Node memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      max_mem[wr_addr] <= wr_max;
      min_mem[wr_addr] <= wr_min;
    end
    rd_max <= max_mem[rd_addr];
    rd_min <= min_mem[rd_addr];
  end

  // Sequencer, walk registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A reload in S_DONE takes over the drop of a taken result
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + mmtt_pkg::ROOT_ADDR;
          if (clr_addr == mmtt_pkg::LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            node_addr <= leaf_addr;
            cur_max   <= in_leaf;
            cur_min   <= in_leaf;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          node_addr <= parent_addr;
          cur_max   <= new_max;
          cur_min   <= new_min;
          if (parent_addr == mmtt_pkg::ROOT_ADDR) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // cur_* now hold the two roots
          if (!m_tvalid || m_tready) begin
            out_any  <= cur_max.valid;
            out_max  <= cur_max.valid ? cur_max : '0;
            out_min  <= cur_max.valid ? cur_min : '0;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_any;
  assign m_tdata = {4'b0, out_min.slot, out_min.key, out_max.slot, out_max.key};

  // Checks
  `MMTT_ASSERT_IMP(a_result_from_done, clk, rst,
    $rose(m_tvalid), $past(state) == S_DONE)
  `MMTT_ASSERT_IMP(a_empty_is_zero, clk, rst,
    m_tvalid && !m_tuser[0], m_tdata == '0)
  `MMTT_ASSERT_IMP(a_min_not_above_max, clk, rst,
    m_tvalid && m_tuser[0], m_tdata[41:26] <= m_tdata[15:0])
  `MMTT_ASSERT_NEXT(a_one_item_in_flight, clk, rst,
    s_tvalid && s_tready, !s_tready)

endmodule

[sim/min_max_tournament_tree_test.sv]
// Self-checking testbench for the min/max tournament tree: directed and random set/clear traffic.
module min_max_tournament_tree_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT  = 1 << mmtt_pkg::SLOT_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  // One update as it travels on the slave side
  typedef struct packed {
    logic                           func;
    logic [mmtt_pkg::SLOT_BITS-1:0] slot;
    logic [mmtt_pkg::KEY_BITS-1:0]  key;
  } slot_update_t;

  // Root summary reported after every update
  typedef struct packed {
    logic                           present;
    logic [mmtt_pkg::KEY_BITS-1:0]  max_key;
    logic [mmtt_pkg::SLOT_BITS-1:0] max_slot;
    logic [mmtt_pkg::KEY_BITS-1:0]  min_key;
    logic [mmtt_pkg::SLOT_BITS-1:0] min_slot;
  } tree_roots_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // slot[9:0], key[25:10], zero pad
  logic [0:0]  s_tuser = '0;   // func[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // max_key, max_slot, min_key, min_slot, zero pad
  logic [0:0]  m_tuser;        // any_present[0]

  min_max_tournament_tree uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Shadow of the slot contents
  bit                            slot_held [SLOT_COUNT];
  logic [mmtt_pkg::KEY_BITS-1:0] slot_key  [SLOT_COUNT];

  slot_update_t pending_updates [$];
  tree_roots_t  expected_roots  [$];
  slot_update_t in_flight;

  int  send_pause;
  int  recv_stall;
  bit  send_idling = 1'b1;
  bit  recv_idling = 1'b1;
  int  mismatches;
  int  cycles;

  // Mostly short gaps, now and then a long one
  function automatic int pick_pause(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one update to the shadow and rescan for both winners.
  // Ascending scan: >= lets the larger slot take max ties, < keeps the smaller for min.
  function automatic tree_roots_t apply_update(slot_update_t u);
    tree_roots_t r;
    bit          found;
    r     = '0;
    found = 1'b0;
    slot_held[u.slot] = (u.func == mmtt_pkg::FUNC_SET);
    slot_key[u.slot]  = u.key;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (slot_held[s]) begin
        if (!found || slot_key[s] >= r.max_key) begin
          r.max_key  = slot_key[s];
          r.max_slot = mmtt_pkg::SLOT_BITS'(s);
        end
        if (!found || slot_key[s] < r.min_key) begin
          r.min_key  = slot_key[s];
          r.min_slot = mmtt_pkg::SLOT_BITS'(s);
        end
        found = 1'b1;
      end
    end
    r.present = found;
    return r;
  endfunction

  function automatic void report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
    end
  endfunction

  // Slave-side driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_roots = {expected_roots, apply_update(in_flight)};
      end
      if (!s_tvalid || s_tready) begin
        if (send_pause > 0) begin
          send_pause--;
          s_tvalid <= 1'b0;
        end else if (pending_updates.size() != 0) begin
          in_flight  = pending_updates.pop_front();
          s_tvalid   <= 1'b1;
          s_tdata    <= {6'd0, in_flight.key, in_flight.slot};
          s_tuser    <= in_flight.func;
          send_pause = pick_pause(send_idling);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Master-side monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          tree_roots_t want;
          want = expected_roots.pop_front();
          report_field("any_present", 32'(want.present), 32'(m_tuser[0]));
          report_field("max_key", 32'(want.max_key), 32'(m_tdata[15:0]));
          report_field("max_slot", 32'(want.max_slot), 32'(m_tdata[25:16]));
          report_field("min_key", 32'(want.min_key), 32'(m_tdata[41:26]));
          report_field("min_slot", 32'(want.min_slot), 32'(m_tdata[51:42]));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        recv_stall = pick_pause(recv_idling);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL min_max_tournament_tree");
      $finish;
    end
  end

  task automatic queue_update(logic func, int slot, int key);
    slot_update_t u;
    u.func = func;
    u.slot = mmtt_pkg::SLOT_BITS'(slot);
    u.key  = mmtt_pkg::KEY_BITS'(key);
    pending_updates = {pending_updates, u};
  endtask

  // Sender holds until every transfer has been answered
  task automatic wait_drained();
    @(negedge clk);
    while (pending_updates.size() != 0 || s_tvalid || expected_roots.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int profile;
    int slot;
    int key;
    logic func;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tree, extremes, ties, clears back to empty
    @(negedge clk);
    queue_update(mmtt_pkg::FUNC_CLEAR, 5, 16'hFFFF);  // clear on an empty tree
    queue_update(mmtt_pkg::FUNC_SET, 0, 0);
    queue_update(mmtt_pkg::FUNC_SET, 1023, 16'hFFFF);
    queue_update(mmtt_pkg::FUNC_SET, 512, 16'hFFFF);  // max tie: larger slot stays
    queue_update(mmtt_pkg::FUNC_SET, 700, 0);         // min tie: smaller slot stays
    queue_update(mmtt_pkg::FUNC_CLEAR, 0, 0);
    queue_update(mmtt_pkg::FUNC_CLEAR, 1023, 0);
    queue_update(mmtt_pkg::FUNC_SET, 512, 16'h5555);  // overwrite
    queue_update(mmtt_pkg::FUNC_SET, 341, 16'hAAAA);
    queue_update(mmtt_pkg::FUNC_CLEAR, 341, 16'h1234);
    queue_update(mmtt_pkg::FUNC_CLEAR, 341, 0);       // clearing an empty slot
    queue_update(mmtt_pkg::FUNC_CLEAR, 512, 0);
    queue_update(mmtt_pkg::FUNC_CLEAR, 700, 0);       // tree empty again
    queue_update(mmtt_pkg::FUNC_SET, 10'h2AA, 16'h00FF);
    queue_update(mmtt_pkg::FUNC_SET, 10'h155, 16'h00FF);
    queue_update(mmtt_pkg::FUNC_SET, 10'h3FF, 16'hFF00);
    queue_update(mmtt_pkg::FUNC_SET, 1, 16'h00FF);
    queue_update(mmtt_pkg::FUNC_CLEAR, 10'h3FF, 0);
    queue_update(mmtt_pkg::FUNC_CLEAR, 1, 0);
    queue_update(mmtt_pkg::FUNC_CLEAR, 10'h155, 0);
    queue_update(mmtt_pkg::FUNC_CLEAR, 10'h2AA, 0);
    wait_drained();

    // Random segments, each followed by a full drain
    for (int seg = 0; seg < 10; seg++) begin
      profile     = seg % 3;
      send_idling = (seg != 4);
      recv_idling = (seg != 4) && (seg != 7);
      for (int n = 0; n < 103; n++) begin
        case (profile)
          0: begin
            // wide traffic, mostly sets
            func = ($urandom_range(0, 99) < 80) ? mmtt_pkg::FUNC_SET : mmtt_pkg::FUNC_CLEAR;
            slot = $urandom_range(0, SLOT_COUNT - 1);
            key  = $urandom_range(0, 16'hFFFF);
          end
          1: begin
            // few slots and few keys: ties and frequent empty trees
            func = ($urandom_range(0, 99) < 50) ? mmtt_pkg::FUNC_SET : mmtt_pkg::FUNC_CLEAR;
            slot = $urandom_range(0, 15);
            key  = $urandom_range(0, 3);
          end
          default: begin
            // top slots, extreme keys mixed with random ones
            func = ($urandom_range(0, 99) < 65) ? mmtt_pkg::FUNC_SET : mmtt_pkg::FUNC_CLEAR;
            slot = $urandom_range(SLOT_COUNT - 16, SLOT_COUNT - 1);
            case ($urandom_range(0, 3))
              0: key = 0;
              1: key = 16'hFFFF;
              default: key = $urandom_range(0, 16'hFFFF);
            endcase
          end
        endcase
        queue_update(func, slot, key);
      end
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("PASS min_max_tournament_tree");
    end else begin
      $display("FAIL min_max_tournament_tree");
    end
    $finish;
  end

endmodule
